/* hdl/rrjs_pkg.sv */
// shared types and constants for the round-robin job scheduler
`default_nettype none

package rrjs_pkg;

   // default number of slots in the job ring
   localparam int QUEUE_DEPTH_DEF = 16;

   // field widths
   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 24;

   // operation codes of an input item
   typedef enum logic [0:0] {
      OP_ADD  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // status codes of a result item
   typedef enum logic [1:0] {
      ST_ADDED = 2'd0,
      ST_FULL  = 2'd1,
      ST_RAN   = 2'd2,
      ST_IDLE  = 2'd3
   } status_type;

   // command held between front queue and engine
   typedef struct packed {
      op_type               operation;
      logic [ID_W-1:0]      job_id;
      logic [BURST_W-1:0]   burst_ticks;
   } cmd_type;

   // one entry of the job ring
   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [BURST_W-1:0]   burst;
      logic [BURST_W-1:0]   served;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // one result item
   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      running_id;
      logic [TIME_W-1:0]    shown_run_time;
      logic                 others_present;
      logic [ID_W-1:0]      tail_id;
      logic [BURST_W-1:0]   tail_remaining;
      logic [ID_W-1:0]      head_id;
      logic [BURST_W-1:0]   head_remaining;
      logic                 finished;
      logic [TIME_W-1:0]    reported_total;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/rrjs_ram.sv */
// generic single-write single-read ram with registered read data
`default_nettype none

module rrjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/rrjs_cmd_queue.sv */
// two-entry front queue that takes request items and hands commands to the engine
`default_nettype none

module rrjs_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rrjs_pkg::cmd_type req_cmd,
   output logic                   cmd_valid,
   output rrjs_pkg::cmd_type      cmd,
   input  wire logic              cmd_pop
);

   rrjs_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;

   // handshake
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (cmd_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_cmd;
      end
   end

endmodule

`default_nettype wire

/* hdl/rrjs_engine.sv */
// back end: job ring, run sequencer and result register
`default_nettype none

module rrjs_engine #(
   parameter int QUEUE_DEPTH = rrjs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire rrjs_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   output rrjs_pkg::rsp_type      rsp,
   input  wire logic              rsp_stall
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_W = rrjs_pkg::TIME_W;
   localparam int BURST_W = rrjs_pkg::BURST_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_HEAD   = 5'b00010,
      S_NEXT   = 5'b00100,
      S_LAST   = 5'b01000,
      S_COMMIT = 5'b10000
   } eng_state_type;

   eng_state_type          state_ff, state_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [TIME_W-1:0]      elapsed_ff, elapsed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rrjs_pkg::rsp_type      rsp_ff, rsp_in;
   rrjs_pkg::slot_type     cur_ff, cur_in;
   rrjs_pkg::slot_type     nxt_ff, nxt_in;
   rrjs_pkg::slot_type     lst_ff, lst_in;

   logic                   ram_we;
   rrjs_pkg::slot_type     ram_wdata;
   logic [PTR_W-1:0]       ram_raddr;
   logic [rrjs_pkg::SLOT_W-1:0] ram_rdata;

   logic                   out_free;
   logic [BURST_W-1:0]     served_inc;
   logic [TIME_W-1:0]      elapsed_inc;
   logic                   job_done;
   logic                   others;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
   endfunction

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

   function automatic logic [BURST_W-1:0] left_of(input rrjs_pkg::slot_type s);
      return (s.served >= s.burst) ? '0 : s.burst - s.served;
   endfunction

   // job ring storage
   rrjs_ram #(
      .WIDTH (rrjs_pkg::SLOT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // per-tick arithmetic on the taken job
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign served_inc  = (cur_ff.served == '1) ? cur_ff.served : cur_ff.served + 1'b1;
   assign elapsed_inc = sat_add(elapsed_ff, TIME_W'(1));
   assign job_done    = !(served_inc < cur_ff.burst);
   assign others      = (count_ff > CNT_W'(1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      elapsed_in   = elapsed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      lst_in       = lst_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = '0;
      ram_raddr    = head_ff;
      unique case (state_ff)
         S_IDLE: begin
            ram_raddr = head_ff;
            if (cmd_valid) begin
               if (cmd.operation == rrjs_pkg::OP_TICK && count_ff != '0) begin
                  cmd_pop  = 1'b1;
                  state_in = S_HEAD;
               end else if (out_free) begin
                  cmd_pop      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (cmd.operation == rrjs_pkg::OP_TICK) begin
                     rsp_in.status = rrjs_pkg::ST_IDLE;
                  end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rsp_in.status = rrjs_pkg::ST_FULL;
                  end else begin
                     rsp_in.status    = rrjs_pkg::ST_ADDED;
                     ram_we           = 1'b1;
                     ram_wdata.id     = cmd.job_id;
                     ram_wdata.burst  = cmd.burst_ticks;
                     ram_wdata.served = '0;
                     tail_in          = wrap_next(tail_ff);
                     count_in         = count_ff + 1'b1;
                  end
               end
            end
         end
         S_HEAD: begin
            ram_raddr = wrap_next(head_ff);
            cur_in    = ram_rdata;
            state_in  = S_NEXT;
         end
         S_NEXT: begin
            ram_raddr = wrap_prev(tail_ff);
            nxt_in    = ram_rdata;
            state_in  = S_LAST;
         end
         S_LAST: begin
            lst_in   = ram_rdata;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.status         = rrjs_pkg::ST_RAN;
               rsp_in.running_id     = cur_ff.id;
               rsp_in.shown_run_time = sat_add(TIME_W'(cur_ff.served), elapsed_ff);
               if (others) begin
                  rsp_in.others_present = 1'b1;
                  rsp_in.tail_id        = lst_ff.id;
                  rsp_in.tail_remaining = left_of(lst_ff);
                  rsp_in.head_id        = nxt_ff.id;
                  rsp_in.head_remaining = left_of(nxt_ff);
               end
               elapsed_in = elapsed_inc;
               head_in    = wrap_next(head_ff);
               if (job_done) begin
                  rsp_in.finished       = 1'b1;
                  rsp_in.reported_total = sat_add(TIME_W'(cur_ff.burst), elapsed_inc);
                  count_in              = count_ff - 1'b1;
               end else begin
                  ram_we           = 1'b1;
                  ram_wdata.id     = cur_ff.id;
                  ram_wdata.burst  = cur_ff.burst;
                  ram_wdata.served = served_inc;
                  tail_in          = wrap_next(tail_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // job and result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      lst_ff <= lst_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

/* hdl/round_robin_job_scheduler_top.sv */
// top level of the round-robin job scheduler, quantum of one tick
// an add or an idle tick gets its registered result straight from S_IDLE
// a tick that runs a job passes S_HEAD, S_NEXT and S_LAST, then registers its result in S_COMMIT
// throughput: adds and idle ticks 1 per cycle unless the result is stalled, a running tick
// holds the engine until S_COMMIT, set by the three job ring reads through its single read port
// reset: synchronous, empties the run queue and clears the elapsed count; ring data is not cleared
`default_nettype none

module round_robin_job_scheduler_top #(
   parameter int QUEUE_DEPTH = rrjs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_job_id,
   input  wire logic [15:0] req_burst_ticks,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_running_id,
   output logic [23:0]      rsp_shown_run_time,
   output logic             rsp_others_present,
   output logic [7:0]       rsp_tail_id,
   output logic [15:0]      rsp_tail_remaining,
   output logic [7:0]       rsp_head_id,
   output logic [15:0]      rsp_head_remaining,
   output logic             rsp_finished,
   output logic [23:0]      rsp_reported_total
);

   rrjs_pkg::cmd_type req_cmd;
   rrjs_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   rrjs_pkg::rsp_type rsp;

   // request item into command form
   always_comb begin
      req_cmd.operation   = rrjs_pkg::op_type'(req_operation);
      req_cmd.job_id      = req_job_id;
      req_cmd.burst_ticks = req_burst_ticks;
   end

   // front queue
   rrjs_cmd_queue u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // back end
   rrjs_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   // result fields
   assign rsp_status         = rsp.status;
   assign rsp_running_id     = rsp.running_id;
   assign rsp_shown_run_time = rsp.shown_run_time;
   assign rsp_others_present = rsp.others_present;
   assign rsp_tail_id        = rsp.tail_id;
   assign rsp_tail_remaining = rsp.tail_remaining;
   assign rsp_head_id        = rsp.head_id;
   assign rsp_head_remaining = rsp.head_remaining;
   assign rsp_finished       = rsp.finished;
   assign rsp_reported_total = rsp.reported_total;

   // engine only takes a command that the queue holds
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty front queue");

   // completion is only reported on a tick that ran a job
   a_finish_on_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_status == rrjs_pkg::ST_RAN))
      else $error("finished flag on a result that did not run a job");

   // queue view fields are zero when no other job remains
   a_view_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_others_present) |->
         (rsp_tail_id == 8'd0 && rsp_head_id == 8'd0 &&
          rsp_tail_remaining == 16'd0 && rsp_head_remaining == 16'd0))
      else $error("queue view fields set without other jobs present");

   // a new result never appears straight out of reset
   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> !$past(reset))
      else $error("result item appeared straight out of reset");

endmodule

`default_nettype wire

/* bench/rrjs_schedule_tracker_pkg.sv */
// schedule tracker: predicts scheduler responses and checks the ones that come out
package rrjs_schedule_tracker_pkg;

   import rrjs_pkg::*;

   class schedule_tracker;

      typedef logic [$clog2(QUEUE_DEPTH_DEF)-1:0] slot_idx_type;

      // copy of the run queue and the tick count
      slot_type         ring_copy [QUEUE_DEPTH_DEF];
      slot_idx_type     head_slot;
      slot_idx_type     tail_slot;
      int               jobs_queued;
      logic [TIME_W-1:0] ticks_elapsed;

      // responses still owed by the block, oldest first
      rsp_type          pending_responses [$];
      int               mismatches;

      function new();
         head_slot     = '0;
         tail_slot     = '0;
         jobs_queued   = 0;
         ticks_elapsed = '0;
         mismatches    = 0;
      endfunction

      // ring slot arithmetic with wrap at the queue depth
      function slot_idx_type slot_after(slot_idx_type p);
         return (p == slot_idx_type'(QUEUE_DEPTH_DEF - 1)) ? '0 : p + 1'b1;
      endfunction

      function slot_idx_type slot_before(slot_idx_type p);
         return (p == '0) ? slot_idx_type'(QUEUE_DEPTH_DEF - 1) : p - 1'b1;
      endfunction

      // 24-bit add that sticks at all ones
      function logic [TIME_W-1:0] add_sat24(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
         logic [TIME_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[TIME_W] ? '1 : s[TIME_W-1:0];
      endfunction

      function logic [BURST_W-1:0] ticks_left(slot_type s);
         return (s.served >= s.burst) ? '0 : s.burst - s.served;
      endfunction

      // work out the response to an accepted item and queue it
      function void accept_request(op_type op, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
         rsp_type  r;
         slot_type cur;
         slot_type last;
         slot_type nxt;
         r = '0;
         if (op == OP_ADD) begin
            if (jobs_queued >= QUEUE_DEPTH_DEF) begin
               r.status = ST_FULL;
            end else begin
               ring_copy[tail_slot].id     = id;
               ring_copy[tail_slot].burst  = burst;
               ring_copy[tail_slot].served = '0;
               tail_slot   = slot_after(tail_slot);
               jobs_queued = jobs_queued + 1;
               r.status    = ST_ADDED;
            end
         end else if (jobs_queued == 0) begin
            r.status = ST_IDLE;
         end else begin
            cur         = ring_copy[head_slot];
            head_slot   = slot_after(head_slot);
            jobs_queued = jobs_queued - 1;
            r.status         = ST_RAN;
            r.running_id     = cur.id;
            r.shown_run_time = add_sat24(TIME_W'(cur.served), ticks_elapsed);
            // tail and head of what is left, one job counts as both
            if (jobs_queued >= 1) begin
               last = ring_copy[slot_before(tail_slot)];
               nxt  = ring_copy[head_slot];
               r.others_present = 1'b1;
               r.tail_id        = last.id;
               r.tail_remaining = ticks_left(last);
               r.head_id        = nxt.id;
               r.head_remaining = ticks_left(nxt);
            end
            if (cur.served != 16'hFFFF)
               cur.served = cur.served + 1'b1;
            ticks_elapsed = add_sat24(ticks_elapsed, TIME_W'(1));
            // unfinished job rejoins at the tail
            if (cur.served < cur.burst) begin
               ring_copy[tail_slot] = cur;
               tail_slot   = slot_after(tail_slot);
               jobs_queued = jobs_queued + 1;
            end else begin
               r.finished       = 1'b1;
               r.reported_total = add_sat24(TIME_W'(cur.burst), ticks_elapsed);
            end
         end
         pending_responses.push_back(r);
      endfunction

      function void compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // compare one response with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            $error("response with none expected, status %0d", got.status);
            mismatches++;
            return;
         end
         want = pending_responses.pop_front();
         compare_field("status", TIME_W'(want.status), TIME_W'(got.status));
         compare_field("running_id", TIME_W'(want.running_id), TIME_W'(got.running_id));
         compare_field("shown_run_time", want.shown_run_time, got.shown_run_time);
         compare_field("others_present", TIME_W'(want.others_present),
                       TIME_W'(got.others_present));
         compare_field("tail_id", TIME_W'(want.tail_id), TIME_W'(got.tail_id));
         compare_field("tail_remaining", TIME_W'(want.tail_remaining),
                       TIME_W'(got.tail_remaining));
         compare_field("head_id", TIME_W'(want.head_id), TIME_W'(got.head_id));
         compare_field("head_remaining", TIME_W'(want.head_remaining),
                       TIME_W'(got.head_remaining));
         compare_field("finished", TIME_W'(want.finished), TIME_W'(got.finished));
         compare_field("reported_total", want.reported_total, got.reported_total);
      endfunction

   endclass

endpackage

/* bench/round_robin_job_scheduler_top_test.sv */
// testbench top for the round-robin job scheduler
module round_robin_job_scheduler_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   import rrjs_pkg::*;
   import rrjs_schedule_tracker_pkg::*;

   localparam int RANDOM_ITEMS = 1625;
   localparam int CALM_ITEMS   = 200;
   localparam int STUCK_LIMIT  = 1000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [7:0]  req_job_id;
   logic [15:0] req_burst_ticks;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_running_id;
   logic [23:0] rsp_shown_run_time;
   logic        rsp_others_present;
   logic [7:0]  rsp_tail_id;
   logic [15:0] rsp_tail_remaining;
   logic [7:0]  rsp_head_id;
   logic [15:0] rsp_head_remaining;
   logic        rsp_finished;
   logic [23:0] rsp_reported_total;

   schedule_tracker tracker;
   bit              idle_on;
   int              stuck_cycles;

   round_robin_job_scheduler_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_job_id         (req_job_id),
      .req_burst_ticks    (req_burst_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_running_id     (rsp_running_id),
      .rsp_shown_run_time (rsp_shown_run_time),
      .rsp_others_present (rsp_others_present),
      .rsp_tail_id        (rsp_tail_id),
      .rsp_tail_remaining (rsp_tail_remaining),
      .rsp_head_id        (rsp_head_id),
      .rsp_head_remaining (rsp_head_remaining),
      .rsp_finished       (rsp_finished),
      .rsp_reported_total (rsp_reported_total)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // offer one item, with an optional gap first, and hold it until taken
   task automatic send_item(input op_type op, input logic [7:0] id, input logic [15:0] burst);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_job_id      <= id;
      req_burst_ticks <= burst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.accept_request(op, id, burst);
   endtask

   // mostly short bursts so jobs keep finishing
   function automatic logic [15:0] pick_burst();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 16'($urandom_range(0, 3));
      else if (r < 92)
         return 16'($urandom_range(4, 12));
      else
         return 16'($urandom_range(13, 60));
   endfunction

   // receiver stall bursts
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status         = status_type'(rsp_status);
         got.running_id     = rsp_running_id;
         got.shown_run_time = rsp_shown_run_time;
         got.others_present = rsp_others_present;
         got.tail_id        = rsp_tail_id;
         got.tail_remaining = rsp_tail_remaining;
         got.head_id        = rsp_head_id;
         got.head_remaining = rsp_head_remaining;
         got.finished       = rsp_finished;
         got.reported_total = rsp_reported_total;
         tracker.check_response(got);
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("round_robin_job_scheduler_top_test NOT OK");
         $finish;
      end
   end

   // stimulus
   initial begin
      int     sent;
      int     phase_len;
      int     add_pct;
      int     k;
      op_type op;
      tracker         = new();
      idle_on         = 1'b1;
      stuck_cycles    = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OP_ADD;
      req_job_id      <= '0;
      req_burst_ticks <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // tick on an empty queue, zero burst job finishing at once
      send_item(OP_TICK, 8'hFF, 16'hFFFF);
      send_item(OP_ADD, 8'h00, 16'h0000);
      send_item(OP_TICK, 8'h00, 16'h0000);
      // one job left after the head, reported as both tail and head
      send_item(OP_ADD, 8'hFF, 16'h0001);
      send_item(OP_ADD, 8'h5A, 16'h0003);
      send_item(OP_TICK, 8'h00, 16'h0000);
      send_item(OP_TICK, 8'h00, 16'h0000);
      // fill the ring, then an add that is refused
      for (k = 1; k <= 15; k++)
         send_item(OP_ADD, k[7:0], 16'(k % 5));
      send_item(OP_ADD, 8'hC3, 16'h0002);
      send_item(OP_TICK, 8'h00, 16'h0000);
      send_item(OP_ADD, 8'h3C, 16'h0001);

      // random phases with a varying mix of adds and ticks
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0:       add_pct = 5;
            1:       add_pct = 15;
            2:       add_pct = 30;
            default: add_pct = 70;
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
               idle_on = 1'b0;
            op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
            send_item(op, 8'($urandom_range(0, 255)), pick_burst());
            sent++;
         end
      end

      // drain the queue, then jobs with the longest bursts
      while (tracker.jobs_queued > 0)
         send_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      send_item(OP_TICK, 8'h00, 16'h0000);
      send_item(OP_ADD, 8'h55, 16'hFFFF);
      send_item(OP_ADD, 8'hAA, 16'h8000);
      repeat (4) send_item(OP_TICK, 8'h00, 16'h0000);

      req_valid <= 1'b0;
      while (tracker.pending_responses.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending_responses.size() == 0)
         $display("round_robin_job_scheduler_top_test OK");
      else
         $display("round_robin_job_scheduler_top_test NOT OK");
      $finish;
   end

endmodule
